// File: sv/stow_pkg.sv
// package: types, constants and codes shared by the sample table offset walker
`default_nettype none
package stow_pkg;

    // table depths and derived widths
    localparam int MAX_CHUNKS = 4096;
    localparam int MAX_GROUPS = 256;
    localparam int CHUNK_AW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int GROUP_AW   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CCW        = CHUNK_AW + 1;
    localparam int GCW        = GROUP_AW + 1;

    // configuration port
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 32;
    localparam logic [CFG_IW-1:0] CFG_CHUNK_COUNT  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_GROUP_COUNT  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_UNIFORM_SIZE = 2'd2;

    // request kinds
    typedef enum logic [1:0] {
        MODE_LOAD_CHUNK = 2'd0,
        MODE_LOAD_GROUP = 2'd1,
        MODE_PACKET     = 2'd2,
        MODE_RESTART    = 2'd3
    } mode_t;

    // input request
    typedef struct packed {
        mode_t        mode;
        logic [11:0]  table_index;
        logic [63:0]  chunk_offset;
        logic [12:0]  group_first_chunk;
        logic [15:0]  group_packets;
        logic [31:0]  packet_size;
        logic [31:0]  packet_duration;
    } stow_req_t;

    // result
    typedef struct packed {
        logic [63:0]  packet_offset;
        logic [31:0]  size_out;
        logic [31:0]  duration_out;
        logic         past_end;
    } stow_res_t;

    // control from the handshake logic to the walker
    typedef struct packed {
        logic restart;   // clear walk state
        logic issue;     // packet accepted, launch table reads
        logic commit;    // table data ready, update walk and emit
    } walk_ctrl_t;

endpackage
`default_nettype wire

// File: sv/stow_chunk_mem.sv
// chunk offset table: one write port, two registered read ports
`default_nettype none
module stow_chunk_mem (
    input  wire logic                          aclk,
    input  wire logic                          wr_en,
    input  wire logic [stow_pkg::CHUNK_AW-1:0] wr_addr,
    input  wire logic [63:0]                   wr_data,
    input  wire logic                          rd_en,
    input  wire logic [stow_pkg::CHUNK_AW-1:0] rd_addr,
    output logic [63:0]                        rd_first,
    output logic [63:0]                        rd_data
);
    import stow_pkg::*;

    logic [63:0] mem [MAX_CHUNKS];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read ports: first chunk and the addressed chunk
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_first <= mem[0];
            rd_data  <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: sv/stow_group_mem.sv
// sample-to-chunk group table: first chunk and packets per chunk
`default_nettype none
module stow_group_mem (
    input  wire logic                          aclk,
    input  wire logic                          wr_en,
    input  wire logic [stow_pkg::GROUP_AW-1:0] wr_addr,
    input  wire logic [12:0]                   wr_start,
    input  wire logic [15:0]                   wr_size,
    input  wire logic                          rd_en,
    input  wire logic [stow_pkg::GROUP_AW-1:0] size_addr,
    input  wire logic [stow_pkg::GROUP_AW-1:0] start_addr,
    output logic [15:0]                        rd_size,
    output logic [12:0]                        rd_start
);
    import stow_pkg::*;

    logic [12:0] start_mem [MAX_GROUPS];
    logic [15:0] size_mem  [MAX_GROUPS];

    // write both fields of one group entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            start_mem[wr_addr] <= wr_start;
            size_mem[wr_addr]  <= wr_size;
        end
    end

    // size of the current group, first chunk of the following group
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_size  <= size_mem[size_addr];
            rd_start <= start_mem[start_addr];
        end
    end

endmodule
`default_nettype wire

// File: sv/stow_walk.sv
// walk state: chunk, group and packet positions and the running offset
`default_nettype none
module stow_walk (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire stow_pkg::walk_ctrl_t          ctrl,
    input  wire logic [stow_pkg::CCW-1:0]      ccount,
    input  wire logic [stow_pkg::GCW-1:0]      gcount,
    input  wire logic [31:0]                   size,
    input  wire logic [63:0]                   chunk_first,
    input  wire logic [63:0]                   chunk_next,
    input  wire logic [15:0]                   grp_size,
    input  wire logic [12:0]                   grp_start,
    output logic [stow_pkg::CHUNK_AW-1:0]      chunk_rd_addr,
    output logic [stow_pkg::GROUP_AW-1:0]      size_rd_addr,
    output logic [stow_pkg::GROUP_AW-1:0]      start_rd_addr,
    output logic [63:0]                        offset,
    output logic                               past_end
);
    import stow_pkg::*;

    logic                fresh_reg, fresh_next;
    logic                ovr_reg, ovr_next;
    logic [CHUNK_AW-1:0] cpos_reg, cpos_next;
    logic [15:0]         pic_reg, pic_next;
    logic [GROUP_AW-1:0] gpos_reg, gpos_next;
    logic [63:0]         ofs_reg, ofs_next;

    // walk position as seen by the current packet
    logic [CHUNK_AW-1:0] cpos_eff;
    logic [15:0]         pic_eff;
    logic [GROUP_AW-1:0] gpos_eff;
    logic [63:0]         ofs_eff;
    logic                ovr_eff;
    logic [15:0]         pic_inc;
    logic [CCW-1:0]      next_chunk;
    logic [GCW-1:0]      next_group;

    // read addresses launched with the packet
    always_comb begin
        cpos_eff      = fresh_reg ? '0 : cpos_reg;
        gpos_eff      = fresh_reg ? '0 : gpos_reg;
        next_chunk    = CCW'(cpos_eff) + CCW'(1);
        next_group    = GCW'(gpos_eff) + GCW'(1);
        chunk_rd_addr = next_chunk[CHUNK_AW-1:0];
        size_rd_addr  = gpos_eff;
        start_rd_addr = next_group[GROUP_AW-1:0];
    end

    // starting point of a fresh walk
    always_comb begin
        pic_eff = fresh_reg ? 16'd0 : pic_reg;
        if (fresh_reg) begin
            ovr_eff = (ccount == '0);
            ofs_eff = (ccount == '0) ? 64'd0 : chunk_first;
        end else begin
            ovr_eff = ovr_reg;
            ofs_eff = ofs_reg;
        end
        offset   = ofs_eff;
        past_end = ovr_eff;
        pic_inc  = pic_eff + 16'd1;
    end

    // advance within a chunk, to the next chunk, or past the end
    always_comb begin
        fresh_next = fresh_reg;
        ovr_next   = ovr_reg;
        cpos_next  = cpos_reg;
        pic_next   = pic_reg;
        gpos_next  = gpos_reg;
        ofs_next   = ofs_reg;
        if (ctrl.restart) begin
            fresh_next = 1'b1;
            ovr_next   = 1'b0;
            cpos_next  = '0;
            pic_next   = '0;
            gpos_next  = '0;
            ofs_next   = '0;
        end else if (ctrl.commit) begin
            fresh_next = 1'b0;
            ovr_next   = ovr_eff;
            cpos_next  = cpos_eff;
            pic_next   = pic_eff;
            gpos_next  = gpos_eff;
            ofs_next   = ofs_eff;
            if (!ovr_eff) begin
                pic_next = pic_inc;
                if (pic_inc < grp_size) begin
                    ofs_next = ofs_eff + 64'(size);
                end else if (next_chunk < ccount) begin
                    cpos_next = next_chunk[CHUNK_AW-1:0];
                    pic_next  = '0;
                    ofs_next  = chunk_next;
                    if (next_group < gcount &&
                        32'(grp_start) == 32'(next_chunk) + 32'd1) begin
                        gpos_next = next_group[GROUP_AW-1:0];
                    end
                end else begin
                    ovr_next = 1'b1;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fresh_reg <= 1'b1;
            ovr_reg   <= 1'b0;
            cpos_reg  <= '0;
            pic_reg   <= '0;
            gpos_reg  <= '0;
            ofs_reg   <= '0;
        end else begin
            fresh_reg <= fresh_next;
            ovr_reg   <= ovr_next;
            cpos_reg  <= cpos_next;
            pic_reg   <= pic_next;
            gpos_reg  <= gpos_next;
            ofs_reg   <= ofs_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/sample_table_offset_walker_core.sv
// top level: handshakes, configuration registers and result register
//
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  stow_req_t  (load, packet, restart)
//  m_       out        m_valid / m_ready  stow_res_t  (one per packet request)
//  cfg_     in         cfg_wr_en          index + 32-bit data, no read-back
//
// loads and restarts complete when accepted; a packet reads the tables in the
// accept cycle and the walk state updates when the registered memory data
// arrive. the result register frees the input side while a result waits; a
// packet whose result cannot be stored holds the block until m_ready.
// reset is synchronous, active low, and clears the walk, the configuration and
// handshake registers; table contents and the result register are not cleared.
`default_nettype none
module sample_table_offset_walker_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire stow_pkg::stow_req_t         s_req,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output stow_pkg::stow_res_t              m_res,
    input  wire logic                        cfg_wr_en,
    input  wire logic [stow_pkg::CFG_IW-1:0] cfg_wr_index,
    input  wire logic [stow_pkg::CFG_DW-1:0] cfg_wr_data
);
    import stow_pkg::*;

    logic [12:0]  chunk_count_reg;
    logic [8:0]   group_count_reg;
    logic [31:0]  uniform_size_reg;
    logic         busy_reg, busy_next;
    logic         m_valid_reg, m_valid_next;
    stow_res_t    res_reg;
    logic [31:0]  size_reg;
    logic [31:0]  dur_reg;

    logic         accept;
    logic         pkt_accept;
    walk_ctrl_t   ctrl;
    logic [CCW-1:0] ccount;
    logic [GCW-1:0] gcount;
    logic         chunk_we, group_we;
    logic [CHUNK_AW-1:0] chunk_rd_addr;
    logic [GROUP_AW-1:0] size_rd_addr, start_rd_addr;
    logic [63:0]  chunk_first, chunk_next;
    logic [15:0]  grp_size;
    logic [12:0]  grp_start;
    logic [63:0]  walk_offset;
    logic         walk_past;

    // request decode
    assign s_ready    = !busy_reg;
    assign accept     = s_valid && s_ready;
    assign pkt_accept = accept && (s_req.mode == MODE_PACKET);
    assign chunk_we   = accept && (s_req.mode == MODE_LOAD_CHUNK) &&
                        (32'(s_req.table_index) < 32'(MAX_CHUNKS));
    assign group_we   = accept && (s_req.mode == MODE_LOAD_GROUP) &&
                        (32'(s_req.table_index) < 32'(MAX_GROUPS));

    always_comb begin
        ctrl.restart = accept && (s_req.mode == MODE_RESTART);
        ctrl.issue   = pkt_accept;
        ctrl.commit  = busy_reg && (!m_valid_reg || m_ready);
    end

    // counts limited to the table depths
    assign ccount = (32'(chunk_count_reg) > 32'(MAX_CHUNKS)) ?
                    CCW'(MAX_CHUNKS) : CCW'(chunk_count_reg);
    assign gcount = (32'(group_count_reg) > 32'(MAX_GROUPS)) ?
                    GCW'(MAX_GROUPS) : GCW'(group_count_reg);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_count_reg  <= '0;
            group_count_reg  <= '0;
            uniform_size_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_CHUNK_COUNT:  chunk_count_reg  <= cfg_wr_data[12:0];
                CFG_GROUP_COUNT:  group_count_reg  <= cfg_wr_data[8:0];
                CFG_UNIFORM_SIZE: uniform_size_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // packet in flight and result valid
    always_comb begin
        busy_next = busy_reg;
        if (pkt_accept) begin
            busy_next = 1'b1;
        end else if (ctrl.commit) begin
            busy_next = 1'b0;
        end
        if (ctrl.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // packet size and duration held while the tables are read
    always_ff @(posedge aclk) begin
        if (pkt_accept) begin
            size_reg <= (uniform_size_reg != 32'd0) ? uniform_size_reg
                                                    : s_req.packet_size;
            dur_reg  <= s_req.packet_duration;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (ctrl.commit) begin
            res_reg.packet_offset <= walk_offset;
            res_reg.size_out      <= size_reg;
            res_reg.duration_out  <= dur_reg;
            res_reg.past_end      <= walk_past;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = res_reg;

    // tables
    stow_chunk_mem u_chunk_mem (
        .aclk     (aclk),
        .wr_en    (chunk_we),
        .wr_addr  (CHUNK_AW'(s_req.table_index)),
        .wr_data  (s_req.chunk_offset),
        .rd_en    (pkt_accept),
        .rd_addr  (chunk_rd_addr),
        .rd_first (chunk_first),
        .rd_data  (chunk_next)
    );

    stow_group_mem u_group_mem (
        .aclk       (aclk),
        .wr_en      (group_we),
        .wr_addr    (GROUP_AW'(s_req.table_index)),
        .wr_start   (s_req.group_first_chunk),
        .wr_size    (s_req.group_packets),
        .rd_en      (pkt_accept),
        .size_addr  (size_rd_addr),
        .start_addr (start_rd_addr),
        .rd_size    (grp_size),
        .rd_start   (grp_start)
    );

    // walk state and offset arithmetic
    stow_walk u_walk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .ccount        (ccount),
        .gcount        (gcount),
        .size          (size_reg),
        .chunk_first   (chunk_first),
        .chunk_next    (chunk_next),
        .grp_size      (grp_size),
        .grp_start     (grp_start),
        .chunk_rd_addr (chunk_rd_addr),
        .size_rd_addr  (size_rd_addr),
        .start_rd_addr (start_rd_addr),
        .offset        (walk_offset),
        .past_end      (walk_past)
    );

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// testbench: directed table and random requests checked against an offset walk predictor
module tb_top;
    import stow_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DIR_CHUNKS     = 3;
    localparam int DIR_GROUPS     = 2;

    // clock, reset and block inputs
    logic                aclk;
    logic                aresetn      = 1'b0;
    logic                s_valid      = 1'b0;
    logic                s_ready;
    stow_req_t           s_req        = '0;
    logic                m_valid;
    logic                m_ready      = 1'b0;
    stow_res_t           m_res;
    logic                cfg_wr_en    = 1'b0;
    logic [CFG_IW-1:0]   cfg_wr_index = CFG_CHUNK_COUNT;
    logic [CFG_DW-1:0]   cfg_wr_data  = '0;

    bit                  idle_on      = 1'b1;
    int                  fail_count   = 0;
    int                  quiet_cycles = 0;

    // predicted tables and load tracking
    logic [63:0]         chunk_offsets   [MAX_CHUNKS];
    logic [12:0]         group_first     [MAX_GROUPS];
    logic [15:0]         group_per_chunk [MAX_GROUPS];
    bit                  chunk_seen      [MAX_CHUNKS];
    bit                  group_seen      [MAX_GROUPS];

    // predicted walk state and registers
    logic [12:0]         walk_chunk   = '0;
    logic [15:0]         walk_packet  = '0;
    logic [7:0]          walk_group   = '0;
    logic [63:0]         walk_offset  = '0;
    logic                walk_fresh   = 1'b1;
    logic                walk_overrun = 1'b0;
    logic [12:0]         cfg_chunks   = '0;
    logic [8:0]          cfg_groups   = '0;
    logic [31:0]         cfg_uniform  = '0;

    stow_res_t           pending_packets[$];

    typedef struct {
        bit        is_cfg;
        stow_req_t req;
        bit        typed;
        stow_res_t want;
    } dir_row_t;

    dir_row_t            directed_rows[$];

    sample_table_offset_walker_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req        (s_req),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_res        (m_res),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    // clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // request builders: unused fields carry random bits
    function automatic stow_req_t random_fields(mode_t m);
        stow_req_t r;
        r.mode              = m;
        r.table_index       = 12'($urandom);
        r.chunk_offset      = {$urandom, $urandom};
        r.group_first_chunk = 13'($urandom);
        r.group_packets     = 16'($urandom);
        r.packet_size       = $urandom;
        r.packet_duration   = $urandom;
        return r;
    endfunction

    function automatic stow_req_t make_chunk(logic [11:0] idx, logic [63:0] off);
        stow_req_t r;
        r = random_fields(MODE_LOAD_CHUNK);
        r.table_index  = idx;
        r.chunk_offset = off;
        return r;
    endfunction

    function automatic stow_req_t make_group(logic [11:0] idx, logic [12:0] first,
                                             logic [15:0] pkts);
        stow_req_t r;
        r = random_fields(MODE_LOAD_GROUP);
        r.table_index       = idx;
        r.group_first_chunk = first;
        r.group_packets     = pkts;
        return r;
    endfunction

    function automatic stow_req_t make_packet(logic [31:0] size, logic [31:0] dur);
        stow_req_t r;
        r = random_fields(MODE_PACKET);
        r.packet_size     = size;
        r.packet_duration = dur;
        return r;
    endfunction

    function automatic dir_row_t row(stow_req_t req, bit typed = 1'b0, stow_res_t want = '0);
        dir_row_t d;
        d.is_cfg = 1'b0;
        d.req    = req;
        d.typed  = typed;
        d.want   = want;
        return d;
    endfunction

    // walk predictor: applies one request, returns 1 when it yields a packet result
    function automatic bit resolve_request(input stow_req_t req, output stow_res_t res);
        int          live_chunks;
        int          live_groups;
        int          nxt;
        logic [31:0] eff_size;
        res = '0;
        case (req.mode)
            MODE_LOAD_CHUNK: begin
                chunk_offsets[req.table_index] = req.chunk_offset;
                chunk_seen[req.table_index]    = 1'b1;
                return 1'b0;
            end
            MODE_LOAD_GROUP: begin
                if (int'(req.table_index) < MAX_GROUPS) begin
                    group_first[req.table_index]     = req.group_first_chunk;
                    group_per_chunk[req.table_index] = req.group_packets;
                    group_seen[req.table_index]      = 1'b1;
                end
                return 1'b0;
            end
            MODE_RESTART: begin
                walk_chunk   = '0;
                walk_packet  = '0;
                walk_group   = '0;
                walk_offset  = '0;
                walk_fresh   = 1'b1;
                walk_overrun = 1'b0;
                return 1'b0;
            end
            default: begin
            end
        endcase

        live_chunks = (int'(cfg_chunks) > MAX_CHUNKS) ? MAX_CHUNKS : int'(cfg_chunks);
        live_groups = (int'(cfg_groups) > MAX_GROUPS) ? MAX_GROUPS : int'(cfg_groups);

        // first packet of a walk starts at chunk 0
        if (walk_fresh) begin
            walk_fresh  = 1'b0;
            walk_chunk  = '0;
            walk_packet = '0;
            walk_group  = '0;
            if (live_chunks == 0) begin
                walk_offset  = '0;
                walk_overrun = 1'b1;
            end else begin
                walk_offset = chunk_offsets[0];
            end
        end

        eff_size = (cfg_uniform != 32'd0) ? cfg_uniform : req.packet_size;
        res.packet_offset = walk_offset;
        res.size_out      = eff_size;
        res.duration_out  = req.packet_duration;
        res.past_end      = walk_overrun;

        // advance within the chunk, or jump to the next chunk and maybe the next group
        if (!walk_overrun) begin
            walk_packet = walk_packet + 16'd1;
            if (walk_packet < group_per_chunk[walk_group]) begin
                walk_offset = walk_offset + 64'(eff_size);
            end else begin
                nxt = int'(walk_chunk) + 1;
                if (nxt < live_chunks) begin
                    walk_chunk  = 13'(nxt);
                    walk_packet = '0;
                    walk_offset = chunk_offsets[nxt];
                    if (int'(walk_group) + 1 < live_groups &&
                        int'(group_first[int'(walk_group) + 1]) == nxt + 1) begin
                        walk_group = walk_group + 8'd1;
                    end
                end else begin
                    walk_overrun = 1'b1;
                end
            end
        end
        return 1'b1;
    endfunction

    // table entry the next packet may touch that was never loaded
    function automatic bit missing_entry(output stow_req_t fill);
        int c;
        int g;
        c = walk_fresh ? 0 : int'(walk_chunk);
        g = walk_fresh ? 0 : int'(walk_group);
        fill = '0;
        if (!chunk_seen[c]) begin
            fill = make_chunk(12'(c), {$urandom, $urandom});
        end else if (c + 1 < MAX_CHUNKS && !chunk_seen[c + 1]) begin
            fill = make_chunk(12'(c + 1), {$urandom, $urandom});
        end else if (!group_seen[g]) begin
            fill = make_group(12'(g), 13'($urandom_range(1, 24)), 16'($urandom_range(0, 4)));
        end else if (g + 1 < MAX_GROUPS && !group_seen[g + 1]) begin
            fill = make_group(12'(g + 1), 13'($urandom_range(1, 24)),
                              16'($urandom_range(0, 4)));
        end else begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // drive one request until accepted, then record what it should produce
    task automatic send_request(input stow_req_t req, input bit typed = 1'b0,
                                input stow_res_t want = '0);
        stow_res_t res;
        while (idle_on && $urandom_range(99) < 18) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (resolve_request(req, res)) pending_packets.push_back(typed ? want : res);
    endtask

    // packet request, preceded by loads of any table entry it could read
    task automatic issue_packet(input stow_req_t req, input bit typed = 1'b0,
                                input stow_res_t want = '0);
        stow_req_t fill;
        while (missing_entry(fill)) send_request(fill);
        send_request(req, typed, want);
    endtask

    // sender idle until every packet result is back and the block has drained
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_packets.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic [31:0] chunks, input logic [31:0] groups,
                                input logic [31:0] uniform);
        settle();
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= CFG_CHUNK_COUNT;
        cfg_wr_data  <= chunks;
        @(posedge aclk);
        cfg_chunks   = chunks[12:0];
        cfg_wr_index <= CFG_GROUP_COUNT;
        cfg_wr_data  <= groups;
        @(posedge aclk);
        cfg_groups   = groups[8:0];
        cfg_wr_index <= CFG_UNIFORM_SIZE;
        cfg_wr_data  <= uniform;
        @(posedge aclk);
        cfg_uniform  = uniform;
        cfg_wr_en    <= 1'b0;
    endtask

    // one random phase: config, well-formed tables, then mixed requests
    task automatic run_phase(input int chunks, input int groups, input logic [31:0] uniform,
                             input int n_items);
        int          live_c;
        int          live_g;
        int          first;
        int          pick;
        int          k;
        logic [31:0] size;
        write_config(32'(chunks), 32'(groups), uniform);
        send_request(random_fields(MODE_RESTART));
        live_c = (chunks > MAX_CHUNKS) ? MAX_CHUNKS : chunks;
        live_g = (groups > MAX_GROUPS) ? MAX_GROUPS : groups;
        for (k = 0; k < live_c && k < 12; k++) begin
            send_request(make_chunk(12'(k), {$urandom, $urandom}));
        end
        // group starts increase so the walk meets each one
        first = 1;
        for (k = 0; k < ((live_g > 1) ? live_g : 1) && k < 8; k++) begin
            send_request(make_group(12'(k), 13'(first), 16'($urandom_range(0, 4))));
            first += $urandom_range(1, 3);
        end
        for (k = 0; k < n_items; k++) begin
            if (k == n_items / 2) settle();
            pick = $urandom_range(99);
            if (pick < 80) begin
                case ($urandom_range(3))
                    0: size = 32'($urandom_range(1, 256));
                    1: size = $urandom;
                    2: size = 32'd0;
                    default: size = 32'hFFFF_FFFF;
                endcase
                issue_packet(make_packet(size, $urandom));
            end else if (pick < 86) begin
                send_request(random_fields(MODE_RESTART));
            end else if (pick < 92) begin
                send_request(make_chunk(($urandom_range(3) == 0) ? 12'($urandom) :
                    12'($urandom_range(0, (live_c + 1 > 4095) ? 4095 : live_c + 1)),
                    {$urandom, $urandom}));
            end else if (pick < 97) begin
                send_request(make_group(
                    12'($urandom_range(0, (live_g + 1 > 255) ? 255 : live_g + 1)),
                    13'($urandom_range(1, (live_c + 1 > 4096) ? 4096 : live_c + 1)),
                    16'($urandom_range(0, 4))));
            end else begin
                send_request(make_group(12'($urandom), 13'($urandom), 16'($urandom)));
            end
        end
    endtask

    // result side: random stalls and field checks against the oldest prediction
    always @(posedge aclk) begin
        stow_res_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_packets.size() == 0) begin
                    $error("result with no packet request waiting: packet_offset %h",
                           m_res.packet_offset);
                    fail_count++;
                end else begin
                    want = pending_packets.pop_front();
                    if (m_res.packet_offset !== want.packet_offset) begin
                        $error("packet_offset: expected %h, got %h",
                               want.packet_offset, m_res.packet_offset);
                        fail_count++;
                    end
                    if (m_res.size_out !== want.size_out) begin
                        $error("size_out: expected %h, got %h", want.size_out, m_res.size_out);
                        fail_count++;
                    end
                    if (m_res.duration_out !== want.duration_out) begin
                        $error("duration_out: expected %h, got %h",
                               want.duration_out, m_res.duration_out);
                        fail_count++;
                    end
                    if (m_res.past_end !== want.past_end) begin
                        $error("past_end: expected %b, got %b", want.past_end, m_res.past_end);
                        fail_count++;
                    end
                end
            end
            m_ready <= !(idle_on && $urandom_range(99) < 18);
        end
    end

    // watchdog on cycles with nothing accepted
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("sample_table_offset_walker_core regression: fail");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        // after reset: empty chunk table, walk starts past the end
        directed_rows.push_back(row(make_packet(32'hFFFF_FFFF, 32'h0), 1'b1,
            stow_res_t'{packet_offset: 64'h0, size_out: 32'hFFFF_FFFF,
                        duration_out: 32'h0, past_end: 1'b1}));
        directed_rows.push_back(row(make_packet(32'h0, 32'hFFFF_FFFF), 1'b1,
            stow_res_t'{packet_offset: 64'h0, size_out: 32'h0,
                        duration_out: 32'hFFFF_FFFF, past_end: 1'b1}));
        directed_rows.push_back(row(random_fields(MODE_RESTART)));
        directed_rows.push_back('{is_cfg: 1'b1, req: '0, typed: 1'b0, want: '0});
        // three chunks, first near the top of the offset range
        directed_rows.push_back(row(make_chunk(12'd0, 64'hFFFF_FFFF_FFFF_FFF0)));
        directed_rows.push_back(row(make_chunk(12'd1, 64'h1000)));
        directed_rows.push_back(row(make_chunk(12'd2, 64'h2000)));
        directed_rows.push_back(row(make_chunk(12'd4095, 64'h0)));
        // group 1 starts at the third chunk with zero packets per chunk
        directed_rows.push_back(row(make_group(12'd0, 13'd1, 16'd2)));
        directed_rows.push_back(row(make_group(12'd1, 13'd3, 16'd0)));
        directed_rows.push_back(row(make_group(12'd255, 13'd4096, 16'hFFFF)));
        // index beyond the group table is dropped
        directed_rows.push_back(row(make_group(12'd4095, 13'd1, 16'd1)));
        directed_rows.push_back(row(make_packet(32'h20, $urandom)));
        // offset wraps past the top
        directed_rows.push_back(row(make_packet(32'd5, 32'h1234), 1'b1,
            stow_res_t'{packet_offset: 64'h10, size_out: 32'd5,
                        duration_out: 32'h1234, past_end: 1'b0}));
        directed_rows.push_back(row(make_packet(32'd7, $urandom)));
        directed_rows.push_back(row(make_packet(32'd9, $urandom)));
        directed_rows.push_back(row(make_packet(32'd3, $urandom)));
        // beyond the last chunk the offset freezes
        directed_rows.push_back(row(make_packet(32'd11, 32'h55), 1'b1,
            stow_res_t'{packet_offset: 64'h2000, size_out: 32'd11,
                        duration_out: 32'h55, past_end: 1'b1}));
        directed_rows.push_back(row(random_fields(MODE_RESTART)));
        directed_rows.push_back(row(make_packet(32'd1, $urandom)));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                write_config(32'(DIR_CHUNKS), 32'(DIR_GROUPS), 32'd0);
            end else if (directed_rows[i].req.mode == MODE_PACKET) begin
                issue_packet(directed_rows[i].req, directed_rows[i].typed,
                             directed_rows[i].want);
            end else begin
                send_request(directed_rows[i].req);
            end
        end

        // random phases across register settings, extremes included
        run_phase(5, 2, 32'd0, 75);
        idle_on = 1'b0;
        run_phase(8191, 511, 32'hFFFF_FFFF, 75);
        idle_on = 1'b1;
        run_phase(0, 0, $urandom, 60);
        run_phase(1, 1, 32'd0, 60);
        run_phase(4096, 256, 32'd0, 75);
        run_phase($urandom_range(2, 20), $urandom_range(0, 6), 32'd0, 75);
        run_phase($urandom_range(2, 20), $urandom_range(1, 6),
                  32'($urandom_range(1, 4096)), 75);
        run_phase($urandom_range(1, 40), $urandom_range(257, 511), 32'd0, 75);

        settle();
        if (pending_packets.size() != 0) begin
            $error("%0d packet results never arrived", pending_packets.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("sample_table_offset_walker_core regression: pass");
        end else begin
            $display("sample_table_offset_walker_core regression: fail");
        end
        $finish;
    end

endmodule
